/* rtl/core/esm_pkg.sv */
package esm_pkg;

    // fixed field widths
    localparam int MODE_W  = 2;
    localparam int ROW_W   = 8;
    localparam int SEG_W   = 6;
    localparam int COL_W   = 4;
    localparam int WORD_W  = 32;
    localparam int ACC_W   = 48;
    localparam int CNT_W   = 16;
    localparam int BATCH_W = 7;
    localparam int EWID_W  = 5;

    localparam int TABLE_ROWS   = 256;
    localparam int EMB_DIM      = 16;
    localparam int MAX_SEGMENTS = 64;

    localparam int TBL_DEPTH = TABLE_ROWS * EMB_DIM;
    localparam int ACC_DEPTH = MAX_SEGMENTS * EMB_DIM;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(EMB_DIM - 1);
    localparam logic [EWID_W-1:0] EWID_MAX  = EWID_W'(EMB_DIM);
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    localparam logic [ACC_W-1:0] ACC_POS_LIM = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_NEG_LIM = {1'b1, {(ACC_W-1){1'b0}}};

    // request modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

    // register indexes
    localparam logic REG_MEAN_MODE = 1'b0;
    localparam logic REG_EMB_WIDTH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_RD   = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    typedef struct packed {
        logic               start;
        logic [ACC_W-1:0]   dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [ACC_W-1:0]   quotient;
    } div_rsp_t;

    // last column index in use; width 0 acts as 1, above EMB_DIM as EMB_DIM
    function automatic logic [COL_W-1:0] last_col(input logic [EWID_W-1:0] ew);
        logic [EWID_W-1:0] w;
        w = ew;
        if (w == '0)
        begin
            w = EWID_W'(1);
        end
        if (w > EWID_MAX)
        begin
            w = EWID_MAX;
        end
        return COL_W'(w - EWID_W'(1));
    endfunction

    function automatic logic [WORD_W-1:0] sat32(input logic [ACC_W-1:0] x);
        logic fits;
        fits = (&x[ACC_W-1:WORD_W-1]) || !(|x[ACC_W-1:WORD_W-1]);
        if (fits)
        begin
            return x[WORD_W-1:0];
        end
        return x[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

endpackage

/* rtl/core/esm_ram.sv */
module esm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/esm_div.sv */
module esm_div
    import esm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic                 neg_reg,   neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [ACC_W-1:0]     q_reg,     q_next;
    logic [CNT_W-1:0]     rem_reg,   rem_next;

    logic [CNT_W:0]       rem_sh;
    logic [CNT_W+1:0]     diff;

    // restoring divide on magnitudes, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, q_reg[ACC_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, req.divisor};
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.dividend[ACC_W-1];
            q_next    = req.dividend[ACC_W-1] ? (~req.dividend + ACC_W'(1)) : req.dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(ACC_W - 1);
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[ACC_W-2:0], ~diff[CNT_W+1]};
            rem_next = diff[CNT_W+1] ? rem_sh[CNT_W-1:0] : diff[CNT_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~q_reg + ACC_W'(1)) : q_reg;

endmodule

/* rtl/core/embedding_segment_sum_mean_unit.sv */
// Embedding-bag segment reduction. A load or a clear is taken while busy stays
// low, and its acknowledgement appears on the next cycle. An accumulate walks
// all EMB_DIM columns through the accumulator memory, one column a cycle, and
// holds busy until the last column is written. A read gives one result a cycle
// for sums, or for a segment with zero count; in mean mode each column of a
// counted segment goes through the bit-serial divider, which is started, then
// works out the 48 quotient bits and hands the quotient back. Results come as a
// one-cycle strobe on result_valid and cannot be held off, so the receiver must
// take every item as it appears. Accumulators and counts are cleared by
// flip-flop row flags, so no clearing pass follows reset.
module embedding_segment_sum_mean_unit
    import esm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MODE_W-1:0]   mode,
    input  logic [ROW_W-1:0]    table_row,
    input  logic [SEG_W-1:0]    segment,
    input  logic [COL_W-1:0]    column,
    input  logic signed [WORD_W-1:0] value,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [EWID_W-1:0]   cfg_data,
    output logic                result_valid,
    output logic signed [WORD_W-1:0] result_value,
    output logic [COL_W-1:0]    result_column,
    output logic                last,
    output logic [BATCH_W-1:0]  batch_count
);

    state_t state_reg, state_next;

    logic                   mean_mode_reg;
    logic [EWID_W-1:0]      emb_width_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [SEG_W-1:0]       seg_reg;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [MAX_SEGMENTS-1:0] seg_valid_reg;
    logic [BATCH_W-1:0]     highest_reg, highest_next;

    logic                   res_valid_reg;
    logic [WORD_W-1:0]      res_value_reg;
    logic [COL_W-1:0]       res_col_reg;
    logic                   res_last_reg;
    logic [BATCH_W-1:0]     res_batch_reg;

    logic                   accept;
    logic [COL_W-1:0]       wlast;

    // memory ports
    logic                   tbl_we, tbl_re;
    logic [WORD_W-1:0]      tbl_rdata;
    logic                   acc_we, acc_re;
    logic [ACC_W-1:0]       acc_wdata, acc_rdata;
    logic                   cnt_we, cnt_re;
    logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;
    logic [ROW_W-1:0]       rd_row;
    logic [SEG_W-1:0]       rd_seg;
    logic [COL_W-1:0]       rd_col;

    // datapath
    logic                   seg_ok;
    logic [ACC_W-1:0]       acc_old;
    logic [CNT_W-1:0]       cnt_old;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_sat;
    logic [BATCH_W-1:0]     seg_plus_one;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // control
    logic                   emit;
    logic [ACC_W-1:0]       emit_val;
    logic [COL_W-1:0]       emit_col;
    logic                   emit_last;
    logic [BATCH_W-1:0]     emit_batch;
    logic                   clr_all;
    logic                   acc_done;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign wlast  = last_col(emb_width_reg);

    assign seg_ok       = seg_valid_reg[seg_reg];
    assign acc_old      = seg_ok ? acc_rdata : '0;
    assign cnt_old      = seg_ok ? cnt_rdata : '0;
    assign acc_sum      = {acc_old[ACC_W-1], acc_old}
                        + {{(ACC_W-WORD_W+1){tbl_rdata[WORD_W-1]}}, tbl_rdata};
    assign acc_sat      = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                        ? (acc_sum[ACC_W] ? ACC_NEG_LIM : ACC_POS_LIM)
                        : acc_sum[ACC_W-1:0];
    assign seg_plus_one = BATCH_W'(seg_reg) + BATCH_W'(1);

    assign rd_row = (state_reg == S_IDLE) ? table_row : row_reg;
    assign rd_seg = (state_reg == S_IDLE) ? segment : seg_reg;

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        tbl_we       = 1'b0;
        tbl_re       = 1'b0;
        acc_re       = 1'b0;
        acc_we       = 1'b0;
        acc_wdata    = acc_old;
        cnt_re       = 1'b0;
        cnt_we       = 1'b0;
        cnt_wdata    = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + CNT_W'(1);
        rd_col       = '0;
        emit         = 1'b0;
        emit_val     = '0;
        emit_col     = '0;
        emit_last    = 1'b1;
        emit_batch   = highest_reg;
        clr_all      = 1'b0;
        acc_done     = 1'b0;
        highest_next = highest_reg;
        div_req.start    = 1'b0;
        div_req.dividend = acc_old;
        div_req.divisor  = cnt_old;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    col_next = '0;
                    unique case (mode)
                        MODE_LOAD:
                        begin
                            tbl_we = 1'b1;
                            emit   = 1'b1;
                        end
                        MODE_ACC:
                        begin
                            tbl_re     = 1'b1;
                            acc_re     = 1'b1;
                            cnt_re     = 1'b1;
                            state_next = S_ACC;
                        end
                        MODE_READ:
                        begin
                            acc_re     = 1'b1;
                            cnt_re     = 1'b1;
                            state_next = S_RD;
                        end
                        MODE_CLEAR:
                        begin
                            clr_all    = 1'b1;
                            emit       = 1'b1;
                            emit_batch = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                // columns past the width in use keep their value; a fresh row
                // is written out in full so stale words never reappear
                acc_we    = 1'b1;
                acc_wdata = (col_reg <= wlast) ? acc_sat : acc_old;
                if (col_reg != COL_LAST)
                begin
                    rd_col   = col_reg + COL_W'(1);
                    col_next = rd_col;
                    tbl_re   = 1'b1;
                    acc_re   = 1'b1;
                end
                else
                begin
                    cnt_we       = 1'b1;
                    acc_done     = 1'b1;
                    highest_next = (seg_plus_one > highest_reg) ? seg_plus_one : highest_reg;
                    emit         = 1'b1;
                    emit_batch   = highest_next;
                    state_next   = S_IDLE;
                end
            end
            S_RD:
            begin
                if (mean_mode_reg && (cnt_old != '0))
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_val = acc_old;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    emit     = 1'b1;
                    emit_val = div_rsp.quotient;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // per-column step of a read
        if (emit && (state_reg == S_RD || state_reg == S_DIV))
        begin
            emit_col  = col_reg;
            emit_last = (col_reg == wlast);
            if (emit_last)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                rd_col     = col_reg + COL_W'(1);
                col_next   = rd_col;
                acc_re     = 1'b1;
                state_next = S_RD;
            end
        end
    end

    esm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr ({table_row, column}),
        .wdata (value),
        .re    (tbl_re),
        .raddr ({rd_row, rd_col}),
        .rdata (tbl_rdata)
    );

    esm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc (
        .clk   (clk),
        .we    (acc_we),
        .waddr ({seg_reg, col_reg}),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr ({rd_seg, rd_col}),
        .rdata (acc_rdata)
    );

    esm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (seg_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (rd_seg),
        .rdata (cnt_rdata)
    );

    esm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mean_mode_reg <= 1'b0;
            emb_width_reg <= EWID_MAX;
            seg_valid_reg <= '0;
            highest_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= emit;
            highest_reg   <= clr_all ? '0 : highest_next;
            if (clr_all)
            begin
                seg_valid_reg <= '0;
            end
            else if (acc_done)
            begin
                seg_valid_reg[seg_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MEAN_MODE: mean_mode_reg <= cfg_data[0];
                    REG_EMB_WIDTH: emb_width_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        if (accept)
        begin
            row_reg <= table_row;
            seg_reg <= segment;
        end
        if (emit)
        begin
            res_value_reg <= sat32(emit_val);
            res_col_reg   <= emit_col;
            res_last_reg  <= emit_last;
            res_batch_reg <= emit_batch;
        end
    end

    assign result_valid  = res_valid_reg;
    assign result_value  = res_value_reg;
    assign result_column = res_col_reg;
    assign last          = res_last_reg;
    assign batch_count   = res_batch_reg;

    // the final item of a request always finds the block idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("last item while busy");

    // an item that is not the last belongs to a read still running
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-last item with block idle");

    // divider finishes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider result not awaited");

    a_state_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule
